/* rtl/dtwf_pkg.sv */
// Shared constants and types for the dual touch weighted filter detector.
// Holds the filter size, reciprocal constants and the stage-advance struct.
// No dependencies.
package dtwf_pkg;

	// Filter size: newest sample weight is 2^(TAPS-1), oldest is 1
	localparam int TAPS       = 4;
	localparam int HIST_DEPTH = TAPS - 1;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int STAMP_W  = 23;

	localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'd2000;

	// Weighted sum plus rounding offset fits in SUM_W bits
	localparam int SUM_W = SAMPLE_W + TAPS;
	localparam longint unsigned DIV = (64'd1 << TAPS) - 64'd1;
	localparam longint unsigned RND = (64'd1 << (TAPS - 1)) - 64'd1;

	// floor(n / DIV) = (n * RECIP_M) >> RECIP_SH for n < 2^SUM_W
	localparam int RECIP_SH = SAMPLE_W + 2 * TAPS;
	localparam int RECIP_W  = SAMPLE_W + TAPS + 1;
	localparam longint unsigned RECIP_M = ((64'd1 << RECIP_SH) + DIV - 64'd1) / DIV;
	localparam int FPROD_W  = SUM_W + RECIP_W;

	// ms to s: floor(t / 1000) = floor((t >> 3) / 125)
	localparam int MS_SHIFT   = 3;
	localparam int MS_DIV     = 125;
	localparam int TQ_W       = TIME_W - MS_SHIFT;
	localparam int SEC_SH     = 36;
	localparam int SEC_M_W    = 30;
	localparam longint unsigned SEC_M = ((64'd1 << SEC_SH) + MS_DIV - 1) / MS_DIV;
	localparam int SPROD_W    = TQ_W + SEC_M_W;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} adv_t;

endpackage

/* rtl/dual_touch_weighted_filter_detect.sv */
// Dual-electrode touch detector. Every input transaction carries a right and
// a left capacitive sample plus a millisecond timestamp and yields exactly one
// output transaction, in order. Each side runs in its own lane through a
// binary-weighted moving average over the newest sample and TAPS-1 older ones
// (newest weight 2^(TAPS-1), halving to 1), divided by 2^TAPS-1 and rounded to
// nearest. The merge stage flags contact when both filtered values are strictly
// above the threshold, reports the smaller filtered value, and passes the
// timestamp converted to whole seconds. Histories reset to 2000; a threshold
// write changes only later compares and never refills them. Throughput is one
// transaction per clock unless m_tready stalls the output. An accepted input
// passes three pipeline registers (weighted sum, reciprocal multiply, merge/output
// register) to output valid. Each stage holds only while the one after it is
// full and stalled, so input is still taken while a result waits.
// Configuration: write the threshold only while the block is idle.
module dual_touch_weighted_filter_detect (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [15:0] right_sample, [31:16] left_sample, [63:32] time_ms
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] touched, [16:1] level, [39:17] stamp_sec
	// Threshold register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [dtwf_pkg::SAMPLE_W-1:0] threshold_q;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          valid_s3;
	logic                          rdy_s2;
	logic                          rdy_s3;
	dtwf_pkg::adv_t                adv;

	logic [dtwf_pkg::SAMPLE_W-1:0] filt_r;
	logic [dtwf_pkg::SAMPLE_W-1:0] filt_l;
	logic [dtwf_pkg::STAMP_W-1:0]  stamp_mid;
	logic                          touched;
	logic [dtwf_pkg::SAMPLE_W-1:0] level;
	logic [dtwf_pkg::STAMP_W-1:0]  stamp_sec;

	// Threshold register: always ready, new value affects later compares only
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= dtwf_pkg::THRESH_RESET;
		end else if (cfg_valid) begin
			threshold_q <= cfg_data;
		end
	end

	// Pipeline control: a stage can load when empty or when the next one drains
	assign rdy_s3   = !valid_s3 || m_tready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign s_tready = !valid_s1 || rdy_s2;

	assign adv.en_s1 = s_tvalid && s_tready;
	assign adv.en_s2 = valid_s1 && rdy_s2;
	assign adv.en_s3 = valid_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Right and left filter lanes
	dtwf_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.sample (s_tdata[15:0]),
		.filt   (filt_r)
	);

	dtwf_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.sample (s_tdata[31:16]),
		.filt   (filt_l)
	);

	// Timestamp conversion, aligned with the lanes
	dtwf_sec u_sec (
		.clk       (clk),
		.adv       (adv),
		.time_ms   (s_tdata[63:32]),
		.stamp_sec (stamp_mid)
	);

	// Compare, minimum and output register
	dtwf_merge u_merge (
		.clk       (clk),
		.adv       (adv),
		.filt_r    (filt_r),
		.filt_l    (filt_l),
		.threshold (threshold_q),
		.stamp_in  (stamp_mid),
		.touched   (touched),
		.level     (level),
		.stamp_sec (stamp_sec)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = {stamp_sec, level, touched};

	// Input back-pressure only when the whole pipeline is full and stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && !m_tready))
		else $error("input stalled with room in the pipeline");

	// A full middle stage that cannot drain keeps its transaction
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rdy_s3) |=> valid_s2)
		else $error("stage 2 transaction dropped under stall");

	// Contact implies the reported minimum level is above threshold
	a_touch_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && touched && !$past(cfg_valid)) |-> (level > threshold_q))
		else $error("touched set with level not above threshold");

	// Seconds never exceed the full-scale millisecond count / 1000
	a_stamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (stamp_sec <= 23'd4294967))
		else $error("stamp_sec out of range");

endmodule

/* rtl/dtwf_lane.sv */
// One filter lane: sample history, binary-weighted sum and divide by 2^TAPS-1.
// Uses dtwf_pkg for sizes, reciprocal constant and the adv_t struct.
module dtwf_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtwf_pkg::adv_t                  adv,
	input  logic [dtwf_pkg::SAMPLE_W-1:0]   sample,
	output logic [dtwf_pkg::SAMPLE_W-1:0]   filt
);

	logic [dtwf_pkg::SAMPLE_W-1:0] hist_q [dtwf_pkg::HIST_DEPTH];
	logic [dtwf_pkg::SUM_W-1:0]    sum;
	logic [dtwf_pkg::SUM_W-1:0]    sum_s1;
	logic [dtwf_pkg::FPROD_W-1:0]  prod;
	logic [dtwf_pkg::SAMPLE_W-1:0] filt_s2;

	// Index 0 is the oldest sample; shift on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dtwf_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= dtwf_pkg::THRESH_RESET;
			end
		end else if (adv.en_s1) begin
			for (int i = 0; i < dtwf_pkg::HIST_DEPTH - 1; i++) begin
				hist_q[i] <= hist_q[i + 1];
			end
			hist_q[dtwf_pkg::HIST_DEPTH-1] <= sample;
		end
	end

	// Rounding offset folded in: floor((sum + RND) / DIV)
	always_comb begin
		sum = (dtwf_pkg::SUM_W'(sample) << dtwf_pkg::HIST_DEPTH)
			+ dtwf_pkg::SUM_W'(dtwf_pkg::RND);
		for (int i = 0; i < dtwf_pkg::HIST_DEPTH; i++) begin
			sum = sum + (dtwf_pkg::SUM_W'(hist_q[i]) << i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			sum_s1 <= sum;
		end
	end

	assign prod = dtwf_pkg::FPROD_W'(sum_s1)
		* dtwf_pkg::FPROD_W'(dtwf_pkg::RECIP_M[dtwf_pkg::RECIP_W-1:0]);

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			filt_s2 <= prod[dtwf_pkg::RECIP_SH +: dtwf_pkg::SAMPLE_W];
		end
	end

	assign filt = filt_s2;

endmodule

/* rtl/dtwf_sec.sv */
// Timestamp path: milliseconds to whole seconds by reciprocal multiply.
// Uses dtwf_pkg for widths, reciprocal constant and the adv_t struct.
module dtwf_sec (
	input  logic                           clk,
	input  dtwf_pkg::adv_t                 adv,
	input  logic [dtwf_pkg::TIME_W-1:0]    time_ms,
	output logic [dtwf_pkg::STAMP_W-1:0]   stamp_sec
);

	logic [dtwf_pkg::TQ_W-1:0]    tq_s1;
	logic [dtwf_pkg::SPROD_W-1:0] prod;
	logic [dtwf_pkg::STAMP_W-1:0] stamp_s2;

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			tq_s1 <= time_ms[dtwf_pkg::TIME_W-1:dtwf_pkg::MS_SHIFT];
		end
	end

	assign prod = dtwf_pkg::SPROD_W'(tq_s1)
		* dtwf_pkg::SPROD_W'(dtwf_pkg::SEC_M[dtwf_pkg::SEC_M_W-1:0]);

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			stamp_s2 <= prod[dtwf_pkg::SEC_SH +: dtwf_pkg::STAMP_W];
		end
	end

	assign stamp_sec = stamp_s2;

endmodule

/* rtl/dtwf_merge.sv */
// Merge stage: threshold compare of both lanes, minimum level, output register.
// Uses dtwf_pkg for widths and the adv_t struct.
module dtwf_merge (
	input  logic                           clk,
	input  dtwf_pkg::adv_t                 adv,
	input  logic [dtwf_pkg::SAMPLE_W-1:0]  filt_r,
	input  logic [dtwf_pkg::SAMPLE_W-1:0]  filt_l,
	input  logic [dtwf_pkg::SAMPLE_W-1:0]  threshold,
	input  logic [dtwf_pkg::STAMP_W-1:0]   stamp_in,
	output logic                           touched,
	output logic [dtwf_pkg::SAMPLE_W-1:0]  level,
	output logic [dtwf_pkg::STAMP_W-1:0]   stamp_sec
);

	logic                          touched_s3;
	logic [dtwf_pkg::SAMPLE_W-1:0] level_s3;
	logic [dtwf_pkg::STAMP_W-1:0]  stamp_s3;

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			touched_s3 <= (filt_r > threshold) && (filt_l > threshold);
			level_s3   <= (filt_r < filt_l) ? filt_r : filt_l;
			stamp_s3   <= stamp_in;
		end
	end

	assign touched   = touched_s3;
	assign level     = level_s3;
	assign stamp_sec = stamp_s3;

endmodule

/* test/tb_dual_touch_weighted_filter_detect.sv */
// Self-checking testbench for dual_touch_weighted_filter_detect.
// Holds its own model of both weighted filter lanes and the threshold compare.
// Depends on rtl/dtwf_pkg.sv and the block's RTL only.
`timescale 1ns / 100ps

module tb_dual_touch_weighted_filter_detect;

	// Pipeline depth from input acceptance to output valid
	localparam int PIPE_LAT = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [15:0] right_sample, [31:16] left_sample, [63:32] time_ms
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [0] touched, [16:1] level, [39:17] stamp_sec
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	typedef struct packed {
		logic                          touched;
		logic [dtwf_pkg::SAMPLE_W-1:0] level;
		logic [dtwf_pkg::STAMP_W-1:0]  stamp_sec;
	} touch_result_t;

	// Model state: one history per electrode, entry 0 oldest
	bit [dtwf_pkg::SAMPLE_W-1:0] lane_hist [0:1][0:dtwf_pkg::HIST_DEPTH-1];
	bit [dtwf_pkg::SAMPLE_W-1:0] thr_model;

	touch_result_t pending_touch [$];

	int mismatch_count = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int touch_count    = 0;
	int thr_writes     = 0;

	// Idle bursts on each side can be switched off for the closing stretch
	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	int snk_stall_left = 0;

	dual_touch_weighted_filter_detect DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Model
	// ---------------------------------------------------------------

	// Weighted average of one lane: newest sample weight 2^(TAPS-1), history
	// weights halve down to 1 for the oldest. Divisor 2^TAPS-1 is odd, so
	// rounding half up never sees an exact tie. Shifts the history as it goes.
	function automatic bit [dtwf_pkg::SAMPLE_W-1:0] smooth_lane(int lane,
			bit [dtwf_pkg::SAMPLE_W-1:0] sample);
		longint unsigned acc;
		longint unsigned tap;
		longint unsigned divisor;
		acc = 64'(sample);
		acc = acc << dtwf_pkg::HIST_DEPTH;
		divisor = (64'd1 << dtwf_pkg::TAPS) - 64'd1;
		for (int i = 0; i < dtwf_pkg::HIST_DEPTH; i++) begin
			tap = 64'(lane_hist[lane][i]);
			acc += tap << i;
			lane_hist[lane][i] = (i + 1 < dtwf_pkg::HIST_DEPTH) ? lane_hist[lane][i + 1]
				: sample;
		end
		return dtwf_pkg::SAMPLE_W'((2 * acc + divisor) / (2 * divisor));
	endfunction

	function automatic touch_result_t predict_touch(bit [15:0] right, bit [15:0] left,
			bit [31:0] time_ms);
		touch_result_t res;
		bit [dtwf_pkg::SAMPLE_W-1:0] fr;
		bit [dtwf_pkg::SAMPLE_W-1:0] fl;
		fr = smooth_lane(0, right);
		fl = smooth_lane(1, left);
		res.touched   = (fr > thr_model) && (fl > thr_model);
		res.level     = (fr < fl) ? fr : fl;
		res.stamp_sec = dtwf_pkg::STAMP_W'(time_ms / 32'd1000);
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Output side: random ready stalls and the result checker
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (snk_stall_left > 0) begin
			snk_stall_left <= snk_stall_left - 1;
			m_tready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
			snk_stall_left <= $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Every output transaction is matched against the oldest prediction
	always @(posedge clk) begin
		touch_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_touch.size() == 0) begin
				report_mismatch("unexpected result, level", m_tdata[16:1], 0);
			end else begin
				want = pending_touch.pop_front();
				if (m_tdata[0] !== want.touched)
					report_mismatch("touched", m_tdata[0], want.touched);
				if (m_tdata[16:1] !== want.level)
					report_mismatch("level", m_tdata[16:1], want.level);
				if (m_tdata[39:17] !== want.stamp_sec)
					report_mismatch("stamp_sec", m_tdata[39:17], want.stamp_sec);
				if (want.touched)
					touch_count++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Input side helpers
	// ---------------------------------------------------------------

	// One sample transaction; valid is left high so back-to-back items
	// stream without a bubble. A random gap may come first.
	task automatic send_sample(input bit [15:0] right, input bit [15:0] left,
			input bit [31:0] time_ms);
		touch_result_t expect_res;
		if (src_idle_en && $urandom_range(0, 6) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {time_ms, left, right};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expect_res = predict_touch(right, left, time_ms);
		pending_touch.insert(pending_touch.size(), expect_res);
		items_sent++;
	endtask

	// Stop sending and wait until every predicted result has been seen
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_touch.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// Threshold write; only called while the pipeline is empty
	task automatic write_threshold(input bit [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		thr_model = value;
		thr_writes++;
	endtask

	function automatic bit [15:0] near_level(int center, int spread);
		int v;
		v = center + $urandom_range(0, 2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	function automatic bit [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0, 1:    return near_level(thr_model, 80);
			2:       return near_level(thr_model, 1500);
			3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Histories come out of reset at 2000 and threshold at 2000
	task automatic test_reset_state();
		send_sample(16'd2000, 16'd2000, 32'd0);
		send_sample(16'd2000, 16'd2000, 32'd1);
		send_sample(16'd2100, 16'd2100, 32'd1999);  // lifts both lanes just above 2000
		send_sample(16'd2100, 16'd1000, 32'd2000);  // one low side blocks contact
	endtask

	// Sample and timestamp extremes, seconds rounding at 999/1000 ms
	task automatic test_field_extremes();
		send_sample(16'hFFFF, 16'hFFFF, 32'd999);
		send_sample(16'hFFFF, 16'h0000, 32'd1000);
		send_sample(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_sample(16'hFFFF, 16'hFFFF, 32'd4294967000);
		send_sample(16'hFFFF, 16'hFFFF, 32'h8000_0000);
		send_sample(16'h0000, 16'h0000, 32'h7FFF_FFFF);
		send_sample(16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
		send_sample(16'h5555, 16'hAAAA, 32'h5555_5555);
	endtask

	// Filter at exactly threshold vs one above; a write keeps the histories
	task automatic test_threshold_edge();
		drain_results();
		write_threshold(16'd2500);
		repeat (4) send_sample(16'd2501, 16'd2501, 32'd5000);  // settles at 2501, touch
		drain_results();
		write_threshold(16'd2501);                             // no refill, equal now
		send_sample(16'd2501, 16'd2501, 32'd6000);
		send_sample(16'd2502, 16'd2501, 32'd7000);
		drain_results();
	endtask

	// Both threshold extremes: 0 touches on any nonzero level, 65535 never
	task automatic test_threshold_extremes();
		write_threshold(16'd0);
		send_sample(16'd0, 16'd0, 32'd10);
		repeat (3) send_sample(16'd0, 16'd0, 32'd11);
		send_sample(16'd1, 16'd1, 32'd12);
		send_sample(16'd2, 16'd2, 32'd13);
		drain_results();
		write_threshold(16'hFFFF);
		repeat (4) send_sample(16'hFFFF, 16'hFFFF, 32'd14);
		drain_results();
	endtask

	// Random traffic in runs of repeated samples so the filters settle on
	// chosen levels; timestamps mostly climb, sometimes jump anywhere
	task automatic test_random_traffic(input int count, input bit [15:0] thr,
			input bit pressure);
		bit [15:0] r;
		bit [15:0] l;
		bit [31:0] t_ms;
		int run;
		int sent;
		drain_results();
		write_threshold(thr);
		t_ms = $urandom;
		sent = 0;
		while (sent < count) begin
			r = pick_sample();
			l = ($urandom_range(0, 2) == 0) ? pick_sample() : near_level(r, 40);
			run = $urandom_range(1, 6);
			for (int k = 0; k < run && sent < count; k++) begin
				if ($urandom_range(0, 4) == 0)
					t_ms = $urandom;
				else
					t_ms += $urandom_range(0, 2000);
				// Occasional noise item inside a run
				if ($urandom_range(0, 7) == 0)
					send_sample(16'($urandom), 16'($urandom), t_ms);
				else
					send_sample(r, l, t_ms);
				sent++;
			end
			// Sender holds off until the pipeline is empty
			if (pressure && $urandom_range(0, 9) == 0)
				drain_results();
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		touch_result_t left_over;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		thr_model = dtwf_pkg::THRESH_RESET;
		for (int i = 0; i < dtwf_pkg::HIST_DEPTH; i++) begin
			lane_hist[0][i] = dtwf_pkg::THRESH_RESET;
			lane_hist[1][i] = dtwf_pkg::THRESH_RESET;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_threshold_edge();
		test_threshold_extremes();

		test_random_traffic(300, 16'($urandom_range(0, 65535)), 1'b0);
		test_random_traffic(150, 16'd0, 1'b0);
		test_random_traffic(100, 16'hFFFF, 1'b0);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		test_random_traffic(120, 16'd2000, 1'b0);      // full rate, no gaps
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		test_random_traffic(250, 16'($urandom_range(1000, 40000)), 1'b1);
		// Closing stretch: both sides run flat out
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		test_random_traffic(300, 16'($urandom_range(0, 65535)), 1'b0);

		drain_results();
		repeat (PIPE_LAT * 4) @(posedge clk);
		while (pending_touch.size() != 0) begin
			left_over = pending_touch.pop_front();
			report_mismatch("missing result, level", 0, left_over.level);
		end

		$display("Covered %0d sample transactions, %0d results (%0d with contact),",
			items_sent, results_seen, touch_count);
		$display("%0d threshold writes incl. 0 and 65535, random gaps and stalls.", thr_writes);
		if (mismatch_count == 0)
			$display("tb_dual_touch_weighted_filter_detect OK");
		else
			$display("tb_dual_touch_weighted_filter_detect NOT OK");
		$finish;
	end

	// Watchdog well past the slowest legal run
	initial begin
		#2000000;
		$display("Timeout with %0d results still pending", pending_touch.size());
		$display("tb_dual_touch_weighted_filter_detect NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
rtl/dtwf_pkg.sv
rtl/dtwf_lane.sv
rtl/dtwf_sec.sv
rtl/dtwf_merge.sv
rtl/dual_touch_weighted_filter_detect.sv
test/tb_dual_touch_weighted_filter_detect.sv
